// File: sv/yrf_pkg.sv
// yrf_pkg: shared constants, codes and types of the yuv420 frame rotate/flip block
// no dependencies; imported by every other file of the block

package yrf_pkg;

	// frame geometry limits
	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * 3 / 2;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int DIM_W       = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 1;
	localparam int POS_W       = DIM_W - 1;
	localparam int PIX_W       = 8;

	// configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_ROTATION     = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_FLIP_MODE    = CFG_IDX_W'(3);

	// rotation codes, quarter turns clockwise
	localparam logic [1:0] ROT_0   = 2'd0;
	localparam logic [1:0] ROT_90  = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;
	localparam logic [1:0] ROT_270 = 2'd3;

	// flip codes
	localparam logic [1:0] FLIP_NONE   = 2'd0;
	localparam logic [1:0] FLIP_ROWS   = 2'd1;
	localparam logic [1:0] FLIP_MIRROR = 2'd2;

	// plane codes
	localparam logic [1:0] PLANE_Y = 2'd0;
	localparam logic [1:0] PLANE_U = 2'd1;
	localparam logic [1:0] PLANE_V = 2'd2;

	// request function codes
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_FETCH = 1'b1;

	// effective configuration
	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [1:0]       rotation;
		logic [1:0]       flip_mode;
	} cfg_t;

	// first stage request: a load or a fetch with its source position
	typedef struct packed {
		logic              is_load;
		logic [PIX_W-1:0]  pixel;
		logic [ADDR_W-1:0] waddr;
		logic [POS_W-1:0]  src_row;
		logic [POS_W-1:0]  src_col;
		logic [DIM_W-1:0]  plane_w;
		logic [1:0]        plane;
		logic              last;
	} req_t;

endpackage

// File: sv/yrf_ifs.sv
// yrf_ifs: valid/ready channel interfaces of the frame rotate/flip block
// depends on yrf_pkg

// request channel: load or fetch one byte
interface yrf_req_if import yrf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             func;
	logic [PIX_W-1:0] pixel_in;

	modport source (output valid, output func, output pixel_in, input ready);
	modport sink (input valid, input func, input pixel_in, output ready);
endinterface

// response channel: one transformed byte
interface yrf_rsp_if import yrf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic             frame_last;

	modport source (output valid, output pixel_out, output frame_last, input ready);
	modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

// configuration write channel
interface yrf_cfg_if import yrf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/yrf_cfg_regs.sv
// yrf_cfg_regs: configuration registers with dimension clamping
// depends on yrf_pkg; feeds yrf_addr_gen and yrf_datapath

module yrf_cfg_regs import yrf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg,
	output logic                  restart
);

	// clamp to 2..limit and force even
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] limit);
		logic [DIM_W-1:0] r;
		r = v;
		if (r > limit) r = limit;
		if (r < DIM_W'(2)) r = DIM_W'(2);
		r[0] = 1'b0;
		return r;
	endfunction

	cfg_t cfg_q;

	// any write to a listed register restarts the positions
	always_comb begin
		case (wr_index)
			REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_ROTATION, REG_FLIP_MODE: restart = wr_en;
			default: restart = 1'b0;
		endcase
	end

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width     <= DIM_W'(640);
			cfg_q.height    <= DIM_W'(480);
			cfg_q.rotation  <= ROT_0;
			cfg_q.flip_mode <= FLIP_NONE;
		end else if (wr_en) begin
			case (wr_index)
				REG_FRAME_WIDTH: begin
					cfg_q.width <= clamp_dim(wr_data[DIM_W-1:0], DIM_W'(MAX_WIDTH));
				end
				REG_FRAME_HEIGHT: begin
					cfg_q.height <= clamp_dim(wr_data[DIM_W-1:0], DIM_W'(MAX_HEIGHT));
				end
				REG_ROTATION: cfg_q.rotation <= wr_data[1:0];
				REG_FLIP_MODE: cfg_q.flip_mode <= wr_data[1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: sv/yrf_addr_gen.sv
// yrf_addr_gen: load and fetch position counters, flip/rotate mapping, stage 1 register
// depends on yrf_pkg; configuration from yrf_cfg_regs

module yrf_addr_gen import yrf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             restart,
	input  logic             adv,
	input  logic             take,
	input  logic             func,
	input  logic [PIX_W-1:0] pixel,
	output req_t             req_s1,
	output logic             vld_s1
);

	// load position
	logic [ADDR_W-1:0] ld_ptr_q;
	logic [POS_W-1:0]  ld_row_q, ld_col_q;
	logic [1:0]        ld_plane_q;
	// fetch position
	logic [POS_W-1:0]  em_row_q, em_col_q;
	logic [1:0]        em_plane_q;

	logic [DIM_W-1:0] ld_pw, ld_ph;
	logic             ld_row_end, ld_col_end;
	logic [DIM_W-1:0] pw, ph, ow, oh;
	logic [DIM_W-1:0] row_x, col_x, fr, fc, sr, sc;
	logic             em_row_end, em_col_end, em_last;
	req_t             req_d;

	// load plane size and end-of-row/plane tests
	always_comb begin
		ld_pw = (ld_plane_q == PLANE_Y) ? cfg.width : (cfg.width >> 1);
		ld_ph = (ld_plane_q == PLANE_Y) ? cfg.height : (cfg.height >> 1);
		ld_col_end = ({1'b0, ld_col_q} == ld_pw - DIM_W'(1));
		ld_row_end = ({1'b0, ld_row_q} == ld_ph - DIM_W'(1));
	end

	// fetch mapping: output position to loaded position
	always_comb begin
		pw = (em_plane_q == PLANE_Y) ? cfg.width : (cfg.width >> 1);
		ph = (em_plane_q == PLANE_Y) ? cfg.height : (cfg.height >> 1);
		if (cfg.rotation == ROT_90 || cfg.rotation == ROT_270) begin
			ow = ph;
			oh = pw;
		end else begin
			ow = pw;
			oh = ph;
		end
		row_x = {1'b0, em_row_q};
		col_x = {1'b0, em_col_q};
		case (cfg.rotation)
			ROT_90: begin
				fr = ph - DIM_W'(1) - col_x;
				fc = row_x;
			end
			ROT_180: begin
				fr = ph - DIM_W'(1) - row_x;
				fc = pw - DIM_W'(1) - col_x;
			end
			ROT_270: begin
				fr = col_x;
				fc = pw - DIM_W'(1) - row_x;
			end
			default: begin
				fr = row_x;
				fc = col_x;
			end
		endcase
		sr = fr;
		sc = fc;
		case (cfg.flip_mode)
			FLIP_ROWS: sr = ph - DIM_W'(1) - fr;
			FLIP_MIRROR: sc = pw - DIM_W'(1) - fc;
			default: ;
		endcase
		em_col_end = (col_x == ow - DIM_W'(1));
		em_row_end = (row_x == oh - DIM_W'(1));
		em_last = (em_plane_q == PLANE_V) && em_row_end && em_col_end;
	end

	// request bundle for stage 1
	always_comb begin
		req_d.is_load = (func == FUNC_LOAD);
		req_d.pixel   = pixel;
		req_d.waddr   = ld_ptr_q;
		req_d.src_row = sr[POS_W-1:0];
		req_d.src_col = sc[POS_W-1:0];
		req_d.plane_w = pw;
		req_d.plane   = em_plane_q;
		req_d.last    = em_last;
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_ptr_q   <= '0;
			ld_row_q   <= '0;
			ld_col_q   <= '0;
			ld_plane_q <= PLANE_Y;
			em_row_q   <= '0;
			em_col_q   <= '0;
			em_plane_q <= PLANE_Y;
		end else if (restart) begin
			ld_ptr_q   <= '0;
			ld_row_q   <= '0;
			ld_col_q   <= '0;
			ld_plane_q <= PLANE_Y;
			em_row_q   <= '0;
			em_col_q   <= '0;
			em_plane_q <= PLANE_Y;
		end else if (take) begin
			if (func == FUNC_LOAD) begin
				ld_ptr_q <= ld_ptr_q + ADDR_W'(1);
				ld_col_q <= ld_col_q + POS_W'(1);
				if (ld_col_end) begin
					ld_col_q <= '0;
					ld_row_q <= ld_row_q + POS_W'(1);
					if (ld_row_end) begin
						ld_row_q <= '0;
						if (ld_plane_q == PLANE_V) begin
							ld_plane_q <= PLANE_Y;
							ld_ptr_q   <= '0;
						end else begin
							ld_plane_q <= ld_plane_q + 2'd1;
						end
					end
				end
			end else begin
				em_col_q <= em_col_q + POS_W'(1);
				if (em_col_end) begin
					em_col_q <= '0;
					em_row_q <= em_row_q + POS_W'(1);
					if (em_row_end) begin
						em_row_q   <= '0;
						em_plane_q <= (em_plane_q == PLANE_V) ? PLANE_Y : em_plane_q + 2'd1;
					end
				end
			end
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= take;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1 <= req_d;
		end
	end

endmodule

// File: sv/yrf_datapath.sv
// yrf_datapath: address multiply, address sum, frame store and result register
// depends on yrf_pkg; takes stage 1 requests from yrf_addr_gen

module yrf_datapath import yrf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  req_t             req_s1,
	input  logic             vld_s1,
	output logic             adv_s1,
	output logic             rsp_valid,
	output logic [PIX_W-1:0] rsp_pixel,
	output logic             rsp_last,
	input  logic             rsp_ready
);

	logic [PIX_W-1:0] frame_mem [STORE_DEPTH];

	// stage 2
	logic              vld_s2, load_s2, last_s2;
	logic [PIX_W-1:0]  pixel_s2;
	logic [ADDR_W-1:0] waddr_s2, prod_s2, area_s2;
	logic [POS_W-1:0]  col_s2;
	logic [1:0]        plane_s2;
	// stage 3
	logic              vld_s3, load_s3, last_s3;
	logic [PIX_W-1:0]  pixel_s3;
	logic [ADDR_W-1:0] addr_s3;
	// result register
	logic              rsp_vld_q, rsp_last_q;
	logic [PIX_W-1:0]  rsp_pix_q;

	logic              out_free, go_s3, free_s3, free_s2;
	logic [ADDR_W-1:0] base, addr_d;

	// stage advance: a stage moves when the next one is empty or moving
	always_comb begin
		out_free = !rsp_vld_q || rsp_ready;
		go_s3    = vld_s3 && (load_s3 || out_free);
		free_s3  = !vld_s3 || go_s3;
		free_s2  = !vld_s2 || free_s3;
		adv_s1   = !vld_s1 || free_s2;
	end

	// plane base and final byte address
	always_comb begin
		case (plane_s2)
			PLANE_U: base = area_s2;
			PLANE_V: base = area_s2 + (area_s2 >> 2);
			default: base = '0;
		endcase
		addr_d = load_s2 ? waddr_s2 : prod_s2 + {{(ADDR_W-POS_W){1'b0}}, col_s2} + base;
	end

	// stage valids and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (free_s2) vld_s2 <= vld_s1;
			if (free_s3) vld_s3 <= vld_s2;
			if (out_free) rsp_vld_q <= vld_s3 && !load_s3;
		end
	end

	// stage 2: row times plane width, luma area
	always_ff @(posedge clk) begin
		if (free_s2) begin
			load_s2  <= req_s1.is_load;
			last_s2  <= req_s1.last;
			pixel_s2 <= req_s1.pixel;
			waddr_s2 <= req_s1.waddr;
			col_s2   <= req_s1.src_col;
			plane_s2 <= req_s1.plane;
			prod_s2  <= {{(ADDR_W-POS_W){1'b0}}, req_s1.src_row}
				* {{(ADDR_W-DIM_W){1'b0}}, req_s1.plane_w};
			area_s2  <= {{(ADDR_W-DIM_W){1'b0}}, cfg.width}
				* {{(ADDR_W-DIM_W){1'b0}}, cfg.height};
		end
	end

	// stage 3: byte address
	always_ff @(posedge clk) begin
		if (free_s3) begin
			load_s3  <= load_s2;
			last_s3  <= last_s2;
			pixel_s3 <= pixel_s2;
			addr_s3  <= addr_d;
		end
	end

	// frame store: one write or one read per cycle
	always_ff @(posedge clk) begin
		if (vld_s3 && load_s3) begin
			frame_mem[addr_s3] <= pixel_s3;
		end
		if (vld_s3 && !load_s3 && out_free) begin
			rsp_pix_q <= frame_mem[addr_s3];
		end
	end

	// result last flag
	always_ff @(posedge clk) begin
		if (out_free) begin
			rsp_last_q <= last_s3;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp_pixel = rsp_pix_q;
	assign rsp_last  = rsp_last_q;

endmodule

// File: sv/yuv420_frame_rotate_flip.sv
// yuv420_frame_rotate_flip: top level of the yuv420 frame store with flip and rotation
// depends on yrf_pkg, yrf_ifs, yrf_cfg_regs, yrf_addr_gen, yrf_datapath
//
// channel  role    content
// req      sink    func (load 0 / fetch 1), pixel_in
// rsp      source  pixel_out, frame_last; one transfer per fetch
// cfg      sink    index, data; always ready
//
// one request is taken each cycle unless the pipeline is stalled; the single-port frame store does one access per cycle
// a fetch passes the stage 1, stage 2 and stage 3 registers and then the result register before its result is valid
// reset clears the positions and sets the configuration; the store is left undefined
// a stalled rsp holds the result register, the pipeline bubbles fill up behind it

module yuv420_frame_rotate_flip import yrf_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	yrf_req_if.sink  req,
	yrf_rsp_if.source rsp,
	yrf_cfg_if.sink  cfg
);

	cfg_t cfg_eff;
	req_t req_s1;
	logic restart, vld_s1, adv_s1, take;

	assign cfg.ready = 1'b1;
	assign req.ready = adv_s1;
	assign take      = req.valid && adv_s1;

	// configuration registers
	yrf_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_eff),
		.restart  (restart)
	);

	// position counters and mapping
	yrf_addr_gen u_addr (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_eff),
		.restart (restart),
		.adv     (adv_s1),
		.take    (take),
		.func    (req.func),
		.pixel   (req.pixel_in),
		.req_s1  (req_s1),
		.vld_s1  (vld_s1)
	);

	// address arithmetic, store and result
	yrf_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_eff),
		.req_s1    (req_s1),
		.vld_s1    (vld_s1),
		.adv_s1    (adv_s1),
		.rsp_valid (rsp.valid),
		.rsp_pixel (rsp.pixel_out),
		.rsp_last  (rsp.frame_last),
		.rsp_ready (rsp.ready)
	);

endmodule
